// ----- design/afi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package for the arming failsafe interlock: command and register codes,
// default parameters, reset values and the item and configuration structs.
// No dependencies.
package afi_pkg;

    // default parameter values
    localparam int MaskWidthDef     = 16;
    localparam int BootBitDef       = 0;
    localparam int SwitchBitDef     = 1;
    localparam int DisarmWaitBitDef = 2;

    // field widths
    localparam int CHAN_W      = 11;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int INDEX_W     = 4;
    localparam int CMD_W       = 2;
    localparam int OUT_MASK_W  = 16;
    localparam int REG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

    // configuration register indexes
    localparam logic [REG_INDEX_W-1:0] REG_ARM_THRESHOLD = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_REARM_TIMEOUT = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_REPEAT_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [CHAN_W-1:0]  ARM_THRESHOLD_RST = 11'd1843;
    localparam logic [TIME_W-1:0]  REARM_TIMEOUT_RST = 32'd5000;
    localparam logic [COUNT_W-1:0] REPEAT_LIMIT_RST  = 8'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] reason_index;
        logic [TIME_W-1:0]  now_ms;
        logic [CHAN_W-1:0]  arm_value;
        logic               arm_valid;
        logic [CHAN_W-1:0]  prearm_value;
        logic               prearm_valid;
    } afi_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  arm_threshold;
        logic [TIME_W-1:0]  rearm_timeout_ms;
        logic [COUNT_W-1:0] repeat_limit;
    } afi_cfg_t;

endpackage
`default_nettype wire

// ----- design/afi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel interfaces of the arming failsafe interlock: command items,
// results and configuration writes. Depends on afi_pkg.
interface afi_item_if;
    logic                          valid;
    logic                          ready;
    logic [afi_pkg::CMD_W-1:0]     cmd;
    logic [afi_pkg::INDEX_W-1:0]   reason_index;
    logic [afi_pkg::TIME_W-1:0]    now_ms;
    logic [afi_pkg::CHAN_W-1:0]    arm_value;
    logic                          arm_valid;
    logic [afi_pkg::CHAN_W-1:0]    prearm_value;
    logic                          prearm_valid;

    modport source (
        output valid, cmd, reason_index, now_ms, arm_value, arm_valid,
               prearm_value, prearm_valid,
        input  ready
    );
    modport sink (
        input  valid, cmd, reason_index, now_ms, arm_value, arm_valid,
               prearm_value, prearm_valid,
        output ready
    );
endinterface

interface afi_result_if;
    logic                            valid;
    logic                            ready;
    logic [afi_pkg::OUT_MASK_W-1:0]  reason_mask;
    logic                            failsafe_active;

    modport source (output valid, reason_mask, failsafe_active, input ready);
    modport sink (input valid, reason_mask, failsafe_active, output ready);
endinterface

interface afi_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [afi_pkg::REG_INDEX_W-1:0]  index;
    logic [afi_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/afi_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Interlock state and the per-transaction update: reason mask, rearm timer,
// entry counter and switch sequence flags. Depends on afi_pkg.
module afi_core #(
    parameter int MASK_WIDTH      = afi_pkg::MaskWidthDef,
    parameter int BOOT_BIT        = afi_pkg::BootBitDef,
    parameter int SWITCH_BIT      = afi_pkg::SwitchBitDef,
    parameter int DISARM_WAIT_BIT = afi_pkg::DisarmWaitBitDef
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire afi_pkg::afi_item_t    item,
    input  wire afi_pkg::afi_cfg_t     cfg,
    output logic [MASK_WIDTH-1:0]      mask,
    output logic [MASK_WIDTH-1:0]      mask_next
);

    localparam logic [MASK_WIDTH-1:0] ONE = {{(MASK_WIDTH-1){1'b0}}, 1'b1};
    // a fixed bit placed beyond the mask has no effect
    localparam logic [MASK_WIDTH-1:0] BOOT_M =
        (BOOT_BIT < MASK_WIDTH) ? (ONE << BOOT_BIT) : '0;
    localparam logic [MASK_WIDTH-1:0] SWITCH_M =
        (SWITCH_BIT < MASK_WIDTH) ? (ONE << SWITCH_BIT) : '0;
    localparam logic [MASK_WIDTH-1:0] DW_M =
        (DISARM_WAIT_BIT < MASK_WIDTH) ? (ONE << DISARM_WAIT_BIT) : '0;
    localparam logic [afi_pkg::COUNT_W-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [MASK_WIDTH-1:0]           mask;
        logic [afi_pkg::TIME_W-1:0]      ts;
        logic                            td;
        logic [afi_pkg::COUNT_W-1:0]     ec;
    } afi_timer_t;

    function automatic afi_timer_t raise_fn(
        input afi_timer_t                 s,
        input logic [MASK_WIDTH-1:0]      b,
        input logic [afi_pkg::TIME_W-1:0] now
    );
        afi_timer_t r;
        r      = s;
        r.mask = s.mask | b;
        // entering failsafe from a clear mask restarts the timer
        if ((b != '0) && (s.mask == '0)) begin
            r.ts = now;
            r.td = 1'b0;
            if (s.ec != COUNT_TOP) begin
                r.ec = s.ec + 1'b1;
            end
        end
        return r;
    endfunction

    logic [MASK_WIDTH-1:0]           mask_reg;
    logic [afi_pkg::TIME_W-1:0]      timer_start_reg;
    logic                            timeout_done_reg;
    logic [afi_pkg::COUNT_W-1:0]     entry_count_reg;
    logic                            repeat_done_reg;
    logic                            prearm_before_arm_reg;
    logic                            both_released_reg;

    afi_timer_t                      timer_next;
    logic                            repeat_done_next;
    logic                            prearm_before_arm_next;
    logic                            both_released_next;
    logic [MASK_WIDTH-1:0]           index_bit;
    logic                            arm_on;
    logic                            pre_on;
    logic [afi_pkg::TIME_W-1:0]      elapsed;

    assign index_bit = (32'(item.reason_index) < MASK_WIDTH)
                     ? (ONE << item.reason_index) : '0;
    assign arm_on = item.arm_valid && (item.arm_value > cfg.arm_threshold);
    assign pre_on = item.prearm_valid && (item.prearm_value > cfg.arm_threshold);

    always_comb
    begin
        timer_next             = '{mask_reg, timer_start_reg, timeout_done_reg,
                                   entry_count_reg};
        repeat_done_next       = repeat_done_reg;
        prearm_before_arm_next = prearm_before_arm_reg;
        both_released_next     = both_released_reg;
        elapsed                = '0;
        unique case (item.cmd)
            afi_pkg::CMD_SET:
            begin
                timer_next = raise_fn(timer_next, index_bit, item.now_ms);
            end
            afi_pkg::CMD_CLEAR:
            begin
                timer_next.mask = timer_next.mask & ~index_bit;
            end
            afi_pkg::CMD_CHECK:
            begin
                // release, prearm alone, then both on clears the switch reason
                if (both_released_reg && prearm_before_arm_reg && pre_on && arm_on)
                begin
                    timer_next.mask    = timer_next.mask & ~SWITCH_M;
                    both_released_next = 1'b0;
                end
                else if (!arm_on)
                begin
                    timer_next = raise_fn(timer_next, SWITCH_M, item.now_ms);
                end
                elapsed = item.now_ms - timer_next.ts;
                if (!timer_next.td && (timer_next.mask != '0) &&
                    (elapsed > cfg.rearm_timeout_ms))
                begin
                    timer_next    = raise_fn(timer_next, DW_M, item.now_ms);
                    timer_next.td = 1'b1;
                end
                if (!repeat_done_next && (timer_next.mask != '0) &&
                    (timer_next.ec > cfg.repeat_limit))
                begin
                    timer_next       = raise_fn(timer_next, DW_M, item.now_ms);
                    repeat_done_next = 1'b1;
                end
                if (item.arm_valid && !arm_on)
                begin
                    timer_next.mask  = timer_next.mask & ~DW_M;
                    timer_next.ec    = '0;
                    repeat_done_next = 1'b0;
                end
                prearm_before_arm_next = pre_on && !arm_on;
                if (!pre_on && !arm_on)
                begin
                    both_released_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg              <= BOOT_M | DW_M;
            timer_start_reg       <= '0;
            timeout_done_reg      <= 1'b0;
            entry_count_reg       <= '0;
            repeat_done_reg       <= 1'b0;
            prearm_before_arm_reg <= 1'b0;
            both_released_reg     <= 1'b0;
        end
        else if (step)
        begin
            mask_reg              <= timer_next.mask;
            timer_start_reg       <= timer_next.ts;
            timeout_done_reg      <= timer_next.td;
            entry_count_reg       <= timer_next.ec;
            repeat_done_reg       <= repeat_done_next;
            prearm_before_arm_reg <= prearm_before_arm_next;
            both_released_reg     <= both_released_next;
        end
    end

    assign mask      = mask_reg;
    assign mask_next = timer_next.mask;

endmodule
`default_nettype wire

// ----- design/arming_failsafe_interlock.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the arming failsafe interlock: input register, interlock
// core, result register and configuration registers.
// Depends on afi_pkg, afi_if and afi_core.
//
//  channel  modport  direction  payload
//  item     sink     in         cmd, reason_index, now_ms, arm/prearm value+valid
//  result   source   out        reason_mask, failsafe_active
//  cfg      sink     in         index, data (always ready)
//
// One transaction per cycle sustained while result.ready is high; an accepted
// item passes the input register, then its update enters the result register.
// The update itself is one pass of compares and a 32-bit subtract. A stalled
// result holds the input register; item.ready drops only while both
// registers are full and result.ready is low. Reset restores the boot state
// and register defaults.
module arming_failsafe_interlock #(
    parameter int MASK_WIDTH      = afi_pkg::MaskWidthDef,
    parameter int BOOT_BIT        = afi_pkg::BootBitDef,
    parameter int SWITCH_BIT      = afi_pkg::SwitchBitDef,
    parameter int DISARM_WAIT_BIT = afi_pkg::DisarmWaitBitDef
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    afi_item_if.sink        item,
    afi_result_if.source    result,
    afi_cfg_if.sink         cfg
);

    afi_pkg::afi_cfg_t              cfg_reg;
    afi_pkg::afi_item_t             item_reg;
    logic                           in_vld_reg;
    logic                           out_vld_reg;
    logic [afi_pkg::OUT_MASK_W-1:0] reason_mask_reg;
    logic                           failsafe_reg;
    logic                           advance;
    logic [MASK_WIDTH-1:0]          state_mask;
    logic [MASK_WIDTH-1:0]          mask_next;
    logic [31:0]                    mask_next_wide;
    logic [31:0]                    state_mask_wide;

    assign advance    = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || advance;
    assign cfg.ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_threshold    <= afi_pkg::ARM_THRESHOLD_RST;
            cfg_reg.rearm_timeout_ms <= afi_pkg::REARM_TIMEOUT_RST;
            cfg_reg.repeat_limit     <= afi_pkg::REPEAT_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                afi_pkg::REG_ARM_THRESHOLD:
                    cfg_reg.arm_threshold <= cfg.data[afi_pkg::CHAN_W-1:0];
                afi_pkg::REG_REARM_TIMEOUT:
                    cfg_reg.rearm_timeout_ms <= cfg.data[afi_pkg::TIME_W-1:0];
                afi_pkg::REG_REPEAT_LIMIT:
                    cfg_reg.repeat_limit <= cfg.data[afi_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_vld_reg <= item.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.cmd          <= item.cmd;
            item_reg.reason_index <= item.reason_index;
            item_reg.now_ms       <= item.now_ms;
            item_reg.arm_value    <= item.arm_value;
            item_reg.arm_valid    <= item.arm_valid;
            item_reg.prearm_value <= item.prearm_value;
            item_reg.prearm_valid <= item.prearm_valid;
        end
        if (advance)
        begin
            reason_mask_reg <= mask_next_wide[afi_pkg::OUT_MASK_W-1:0];
            failsafe_reg    <= |mask_next;
        end
    end

    afi_core #(
        .MASK_WIDTH      (MASK_WIDTH),
        .BOOT_BIT        (BOOT_BIT),
        .SWITCH_BIT      (SWITCH_BIT),
        .DISARM_WAIT_BIT (DISARM_WAIT_BIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .mask      (state_mask),
        .mask_next (mask_next)
    );

    assign mask_next_wide  = 32'(mask_next);
    assign state_mask_wide = 32'(state_mask);

    assign result.valid           = out_vld_reg;
    assign result.reason_mask     = reason_mask_reg;
    assign result.failsafe_active = failsafe_reg;

    // state moves only with a transaction
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_mask))
        else $error("interlock state changed without a transaction");

    // every update leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("update produced no result");

    // the result shows the committed state
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result.reason_mask == state_mask_wide[afi_pkg::OUT_MASK_W-1:0])
                    && (result.failsafe_active == (state_mask != '0)))
        else $error("result differs from committed mask");

endmodule
`default_nettype wire

// ----- bench/arming_failsafe_interlock_checker.sv -----
`timescale 1ns / 1ps
// Checker for the arming failsafe interlock: follows the item, result and
// configuration channels, predicts each result and compares it on arrival.
// Depends on afi_pkg and afi_if.
module arming_failsafe_interlock_checker #(
    parameter int MASK_WIDTH      = afi_pkg::MaskWidthDef,
    parameter int BOOT_BIT        = afi_pkg::BootBitDef,
    parameter int SWITCH_BIT      = afi_pkg::SwitchBitDef,
    parameter int DISARM_WAIT_BIT = afi_pkg::DisarmWaitBitDef
) (
    input  logic   clk,
    input  logic   rst_n,
    afi_item_if    item,
    afi_result_if  result,
    afi_cfg_if     cfg,
    output int     fail_count,
    output int     pending
);
    import afi_pkg::*;

    localparam logic [63:0] FULL_MASK64 = (64'd1 << MASK_WIDTH) - 64'd1;
    localparam logic [31:0] WIDTH_MASK  = 32'(FULL_MASK64);

    typedef struct packed {
        logic [OUT_MASK_W-1:0] reason_mask;
        logic                  failsafe_active;
    } mask_report_t;

    mask_report_t expected_masks[$];

    // predicted interlock state
    logic [31:0]        fs_mask;
    logic [TIME_W-1:0]  window_start;
    logic               window_expired;
    logic [COUNT_W-1:0] entries;
    logic               repeat_flagged;
    logic               prearm_first;
    logic               released;

    // register copies
    logic [CHAN_W-1:0]  threshold;
    logic [TIME_W-1:0]  timeout_ms;
    logic [COUNT_W-1:0] entry_limit;

    function automatic logic [31:0] reason_bit(int pos);
        if (pos < 0 || pos >= 32)
            return '0;
        return (32'd1 << pos) & WIDTH_MASK;
    endfunction

    function automatic void reset_model();
        threshold      = ARM_THRESHOLD_RST;
        timeout_ms     = REARM_TIMEOUT_RST;
        entry_limit    = REPEAT_LIMIT_RST;
        fs_mask        = reason_bit(BOOT_BIT) | reason_bit(DISARM_WAIT_BIT);
        window_start   = '0;
        window_expired = 1'b0;
        entries        = '0;
        repeat_flagged = 1'b0;
        prearm_first   = 1'b0;
        released       = 1'b0;
    endfunction

    // a set that lifts an empty mask opens a failsafe window
    function automatic void raise_reason(int pos, logic [TIME_W-1:0] now);
        logic [31:0] b;
        logic [31:0] prev;
        b       = reason_bit(pos);
        prev    = fs_mask;
        fs_mask = (fs_mask | b) & WIDTH_MASK;
        if (b != 0 && prev == 0)
        begin
            window_start   = now;
            window_expired = 1'b0;
            if (entries != '1)
                entries++;
        end
    endfunction

    function automatic void lower_reason(int pos);
        fs_mask = fs_mask & ~reason_bit(pos) & WIDTH_MASK;
    endfunction

    function automatic void run_switch_check(afi_item_t it);
        logic              arm_on;
        logic              pre_on;
        logic [TIME_W-1:0] elapsed;
        arm_on = it.arm_valid && (it.arm_value > threshold);
        pre_on = it.prearm_valid && (it.prearm_value > threshold);

        if (released && prearm_first && pre_on && arm_on)
        begin
            lower_reason(SWITCH_BIT);
            released = 1'b0;
        end
        else if (!arm_on)
            raise_reason(SWITCH_BIT, it.now_ms);

        elapsed = it.now_ms - window_start;
        if (!window_expired && fs_mask != 0 && elapsed > timeout_ms)
        begin
            raise_reason(DISARM_WAIT_BIT, it.now_ms);
            window_expired = 1'b1;
        end
        if (!repeat_flagged && fs_mask != 0 && entries > entry_limit)
        begin
            raise_reason(DISARM_WAIT_BIT, it.now_ms);
            repeat_flagged = 1'b1;
        end
        // a valid arm channel in the off position ends the disarm wait
        if (it.arm_valid && !arm_on)
        begin
            lower_reason(DISARM_WAIT_BIT);
            entries        = '0;
            repeat_flagged = 1'b0;
        end

        prearm_first = pre_on && !arm_on;
        if (!pre_on && !arm_on)
            released = 1'b1;
    endfunction

    function automatic mask_report_t predict_mask(afi_item_t it);
        mask_report_t rep;
        case (it.cmd)
            CMD_SET:   raise_reason(int'(it.reason_index), it.now_ms);
            CMD_CLEAR: lower_reason(int'(it.reason_index));
            CMD_CHECK: run_switch_check(it);
            default:   ;
        endcase
        rep.reason_mask     = fs_mask[OUT_MASK_W-1:0];
        rep.failsafe_active = (fs_mask != 0);
        return rep;
    endfunction

    function automatic void write_register(logic [REG_INDEX_W-1:0] index,
                                           logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_ARM_THRESHOLD: threshold   = data[CHAN_W-1:0];
            REG_REARM_TIMEOUT: timeout_ms  = data[TIME_W-1:0];
            REG_REPEAT_LIMIT:  entry_limit = data[COUNT_W-1:0];
            default:           ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mask_report_t want;
        afi_item_t    seen;
        if (!rst_n)
        begin
            reset_model();
            expected_masks.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // results leave before the same edge's item is predicted
            if (result.valid && result.ready)
            begin
                if (expected_masks.size() == 0)
                begin
                    $error("result transaction with nothing expected: mask %h",
                           result.reason_mask);
                    fail_count++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (result.reason_mask !== want.reason_mask)
                    begin
                        $error("reason_mask: expected %h, got %h",
                               want.reason_mask, result.reason_mask);
                        fail_count++;
                    end
                    if (result.failsafe_active !== want.failsafe_active)
                    begin
                        $error("failsafe_active: expected %b, got %b",
                               want.failsafe_active, result.failsafe_active);
                        fail_count++;
                    end
                end
            end

            if (cfg.valid && cfg.ready)
                write_register(cfg.index, cfg.data);

            if (item.valid && item.ready)
            begin
                seen.cmd          = item.cmd;
                seen.reason_index = item.reason_index;
                seen.now_ms       = item.now_ms;
                seen.arm_value    = item.arm_value;
                seen.arm_valid    = item.arm_valid;
                seen.prearm_value = item.prearm_value;
                seen.prearm_valid = item.prearm_valid;
                expected_masks.push_back(predict_mask(seen));
            end

            pending = expected_masks.size();
        end
    end

endmodule

// ----- bench/arming_failsafe_interlock_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the arming failsafe interlock: clock, reset, item and
// configuration stimulus, result back-pressure and the verdict.
// Depends on afi_pkg, afi_if, the block and arming_failsafe_interlock_checker.
module arming_failsafe_interlock_tb;
    import afi_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LONG_HOLD   = 200;
    localparam int PHASE_ITEMS = 34;
    localparam int SAT_PAIRS   = 260;

    logic clk;
    logic rst_n;

    afi_item_if   item_ch ();
    afi_result_if result_ch ();
    afi_cfg_if    cfg_ch ();

    int fail_count;
    int pending;

    // stimulus control shared with the result sink
    int hold_requests = 0;
    int holds_done    = 0;
    bit rx_mode       = 1'b0;
    bit tx_gaps       = 1'b1;
    int burst_left    = 0;
    int items_sent    = 0;

    // register values as last written, and the current stimulus time
    logic [CHAN_W-1:0] thr_now;
    logic [TIME_W-1:0] timeout_now;
    logic [TIME_W-1:0] clock_ms;

    arming_failsafe_interlock uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    arming_failsafe_interlock_checker interlock_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(400000 * 8);
        $display("[arming_failsafe_interlock] ERROR");
        $finish;
    end

    // result sink: always ready, a rotating stall pattern, or a long counted hold on request
    initial
    begin : result_sink
        int         slot;
        logic [7:0] pattern;
        slot    = 0;
        pattern = 8'hFF;
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_done++;
            end
            else if (!rx_mode)
                result_ch.ready <= 1'b1;
            else
            begin
                if (slot == 0)
                    pattern = 8'($urandom) | 8'h01;
                result_ch.ready <= pattern[slot % 8];
                slot = (slot + 1) % 64;
            end
        end
    end

    function automatic logic [TIME_W-1:0] advance_clock();
        case ($urandom_range(0, 19))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms += timeout_now + $urandom_range(0, 2);
            default: clock_ms += $urandom_range(0, 400);
        endcase
        return clock_ms;
    endfunction

    // channel value on or off against the current threshold
    function automatic void pick_channel(input bit on, output logic [CHAN_W-1:0] v,
                                         output logic ok);
        if (on && thr_now != '1)
        begin
            ok = 1'b1;
            v  = CHAN_W'($urandom_range(int'(thr_now) + 1, 2047));
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            ok = 1'b0;
            v  = CHAN_W'($urandom);
        end
        else
        begin
            ok = 1'b1;
            v  = CHAN_W'($urandom_range(0, int'(thr_now)));
        end
    endfunction

    function automatic afi_item_t fixed_item(logic [CMD_W-1:0] op, logic [INDEX_W-1:0] idx,
                                             logic [TIME_W-1:0] now,
                                             logic [CHAN_W-1:0] av, logic aok,
                                             logic [CHAN_W-1:0] pv, logic pok);
        afi_item_t it;
        it.cmd          = op;
        it.reason_index = idx;
        it.now_ms       = now;
        it.arm_value    = av;
        it.arm_valid    = aok;
        it.prearm_value = pv;
        it.prearm_valid = pok;
        return it;
    endfunction

    function automatic afi_item_t noise_item();
        return fixed_item(CMD_W'($urandom_range(0, 3)), INDEX_W'($urandom), advance_clock(),
                          CHAN_W'($urandom), 1'($urandom), CHAN_W'($urandom),
                          1'($urandom));
    endfunction

    function automatic afi_item_t reason_item(logic [CMD_W-1:0] op,
                                              logic [INDEX_W-1:0] idx);
        return fixed_item(op, idx, advance_clock(), CHAN_W'($urandom), 1'($urandom),
                          CHAN_W'($urandom), 1'($urandom));
    endfunction

    function automatic afi_item_t check_item(bit arm_on, bit pre_on);
        afi_item_t it;
        it = fixed_item(CMD_CHECK, INDEX_W'($urandom), advance_clock(), '0, 1'b0, '0, 1'b0);
        pick_channel(arm_on, it.arm_value, it.arm_valid);
        pick_channel(pre_on, it.prearm_value, it.prearm_valid);
        return it;
    endfunction

    function automatic afi_item_t mixed_item();
        logic [INDEX_W-1:0] idx;
        idx = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 3))
                                   : INDEX_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1, 2: return reason_item(CMD_SET, idx);
            3, 4, 5: return reason_item(CMD_CLEAR, idx);
            default: return check_item(1'($urandom), 1'($urandom));
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic push(input afi_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = 0;
            if (tx_gaps)
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 4);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_ch.valid        <= 1'b1;
        item_ch.cmd          <= it.cmd;
        item_ch.reason_index <= it.reason_index;
        item_ch.now_ms       <= it.now_ms;
        item_ch.arm_value    <= it.arm_value;
        item_ch.arm_valid    <= it.arm_valid;
        item_ch.prearm_value <= it.prearm_value;
        item_ch.prearm_valid <= it.prearm_valid;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // stop offering until every result has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_register(input logic [REG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] word;
        word = value;
        if (index == REG_ARM_THRESHOLD)
        begin
            word[CFG_DATA_W-1:CHAN_W] = (CFG_DATA_W-CHAN_W)'($urandom);
            thr_now = value[CHAN_W-1:0];
        end
        else if (index == REG_REPEAT_LIMIT)
            word[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W-COUNT_W)'($urandom);
        else
            timeout_now = value;
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= word;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [CHAN_W-1:0] thr, input logic [TIME_W-1:0] tmo,
                             input logic [COUNT_W-1:0] rep);
        set_register(REG_ARM_THRESHOLD, CFG_DATA_W'(thr));
        set_register(REG_REARM_TIMEOUT, CFG_DATA_W'(tmo));
        set_register(REG_REPEAT_LIMIT, CFG_DATA_W'(rep));
    endtask

    // optional boot clear, optional release and prearm alone, both on, then some traffic
    task automatic arming_episode();
        if ($urandom_range(0, 1))
            push(reason_item(CMD_CLEAR, INDEX_W'(BootBitDef)));
        if ($urandom_range(0, 5) != 0)
            push(check_item(1'b0, 1'b0));
        if ($urandom_range(0, 5) != 0)
            push(check_item(1'b0, 1'b1));
        push(check_item(1'b1, 1'b1));
        repeat ($urandom_range(1, 6)) push(mixed_item());
    endtask

    initial
    begin : stimulus
        int phase_start;
        bit hold_asked;
        bit drained;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.cmd          = CMD_SET;
        item_ch.reason_index = '0;
        item_ch.now_ms       = '0;
        item_ch.arm_value    = '0;
        item_ch.arm_valid    = 1'b0;
        item_ch.prearm_value = '0;
        item_ch.prearm_valid = 1'b0;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_ARM_THRESHOLD;
        cfg_ch.data          = '0;
        thr_now              = ARM_THRESHOLD_RST;
        timeout_now          = REARM_TIMEOUT_RST;
        clock_ms             = '0;
        hold_asked           = 1'b0;
        drained              = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset settings
        push(fixed_item(CMD_CHECK, '0, 32'd0, 11'd2047, 1'b0, 11'd2047, 1'b0));
        push(fixed_item(CMD_UNUSED, INDEX_W'(15), 32'hFFFF_FFFF, 11'd2047, 1'b1,
                        11'd2047, 1'b1));
        push(fixed_item(CMD_SET, INDEX_W'(15), 32'd10, 11'd0, 1'b0, 11'd0, 1'b0));
        push(fixed_item(CMD_CLEAR, INDEX_W'(15), 32'd20, 11'd0, 1'b0, 11'd0, 1'b0));
        push(fixed_item(CMD_CLEAR, '0, 32'd30, 11'd0, 1'b0, 11'd0, 1'b0));
        push(fixed_item(CMD_CHECK, '0, 32'd40, 11'd0, 1'b1, 11'd0, 1'b1));
        push(fixed_item(CMD_CHECK, '0, 32'd50, 11'd1843, 1'b1, 11'd1844, 1'b1));
        push(fixed_item(CMD_CHECK, '0, 32'd60, 11'd1844, 1'b1, 11'd2047, 1'b1));
        // window opened just below the wrap, checked just past it
        push(fixed_item(CMD_SET, INDEX_W'(5), 32'hFFFF_FF00, 11'd0, 1'b0, 11'd0, 1'b0));
        push(fixed_item(CMD_CHECK, '0, 32'h0000_1300, 11'd2047, 1'b1, 11'd2047, 1'b1));
        push(fixed_item(CMD_CHECK, '0, 32'h0000_1310, 11'd1843, 1'b1, 11'd0, 1'b0));
        push(fixed_item(CMD_CLEAR, INDEX_W'(1), 32'h0000_1320, 11'd0, 1'b0, 11'd0, 1'b0));
        push(fixed_item(CMD_CLEAR, INDEX_W'(5), 32'h0000_1321, 11'd0, 1'b0, 11'd0, 1'b0));
        // repeated entries beyond the limit
        for (int k = 0; k < 7; k++)
            push(fixed_item((k % 2 == 0) ? CMD_SET : CMD_CLEAR, INDEX_W'(3),
                            32'h0000_1322 + 32'(k), 11'd0, 1'b0, 11'd0, 1'b0));
        push(fixed_item(CMD_CHECK, '0, 32'h0000_1330, 11'd2047, 1'b1, 11'd2047, 1'b0));
        push(fixed_item(CMD_SET, '0, 32'h0000_1331, 11'd0, 1'b0, 11'd0, 1'b0));
        push(fixed_item(CMD_CLEAR, INDEX_W'(2), 32'h0000_1332, 11'd0, 1'b0, 11'd0, 1'b0));
        clock_ms = 32'h0000_1400;

        // entry counter driven to its top value
        set_register(REG_REPEAT_LIMIT, 32'd254);
        set_register(REG_REARM_TIMEOUT, 32'hFFFF_FFFF);
        push(fixed_item(CMD_CHECK, '0, advance_clock(), 11'd0, 1'b1, 11'd0, 1'b1));
        push(fixed_item(CMD_CHECK, '0, advance_clock(), 11'd0, 1'b1, 11'd2047, 1'b1));
        push(fixed_item(CMD_CHECK, '0, advance_clock(), 11'd2047, 1'b1, 11'd2047, 1'b1));
        for (int k = 0; k < 16; k++)
            push(reason_item(CMD_CLEAR, INDEX_W'(k)));
        repeat (SAT_PAIRS)
        begin
            push(reason_item(CMD_SET, INDEX_W'(7)));
            push(reason_item(CMD_CLEAR, INDEX_W'(7)));
        end
        push(reason_item(CMD_SET, INDEX_W'(7)));
        push(fixed_item(CMD_CHECK, '0, advance_clock(), 11'd2047, 1'b1, 11'd0, 1'b0));

        // random phases over several register settings
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: configure(ARM_THRESHOLD_RST, REARM_TIMEOUT_RST, REPEAT_LIMIT_RST);
                1: configure(11'd0, 32'd0, 8'd0);
                2: configure(11'd2047, 32'hFFFF_FFFF, 8'd255);
                4: configure(11'd1024, 32'd1000, 8'd1);
                6: configure(ARM_THRESHOLD_RST, REARM_TIMEOUT_RST, REPEAT_LIMIT_RST);
                default: configure(CHAN_W'($urandom), TIME_W'($urandom_range(0, 20000)),
                                   COUNT_W'($urandom_range(0, 8)));
            endcase
            tx_gaps = (p != 1);
            rx_mode = (p != 1 && p != 5);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (p == 0 && !hold_asked && items_sent - phase_start >= 10)
                begin
                    hold_requests++;
                    hold_asked = 1'b1;
                end
                if (p == 4 && !drained && items_sent - phase_start >= 18)
                begin
                    drain();
                    drained = 1'b1;
                end
                if ($urandom_range(0, 9) < 7)
                    arming_episode();
                else
                    push(noise_item());
            end
        end

        item_ch.valid <= 1'b0;
        phase_start = 0;
        while (pending != 0 && phase_start < 5000)
        begin
            @(negedge clk);
            phase_start++;
        end
        if (pending != 0)
        begin
            $display("[arming_failsafe_interlock] ERROR");
            $finish;
        end
        else
        begin
            repeat (8) @(negedge clk);
            if (fail_count == 0)
                $display("[arming_failsafe_interlock] OK");
            else
                $display("[arming_failsafe_interlock] ERROR");
            $finish;
        end
    end

endmodule
